// File: hdl/pfs_pkg.sv
package pfs_pkg;

  typedef enum logic [1:0] {
    OP_BUILD  = 2'd0,
    OP_FACTOR = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BELOW_TWO = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_NO_TABLE  = 3'd3,
    ST_PAST_END  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_B_CLR,     // write 0 at each table entry below the size, 1 at entry 1
    S_B_RD,      // issue read of table[i]
    S_B_CHK,     // read data valid: prime or not
    S_B_MARK,    // write i at multiples
    S_F_RD,      // issue read of table[n]
    S_F_WAIT,
    S_F_DIV,     // restoring divide n / p, one bit a cycle
    S_R_RD,
    S_R_WAIT,
    S_OUT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  localparam int MAX_OUT       = 16;
  localparam int VAL_W         = 16;
  localparam int CNT_W         = 14;
  localparam int TABLE_ENTRIES = 65536;
  localparam int PRIME_SLOTS   = 8192;

endpackage

// File: hdl/pfs_ram.sv
module pfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/pfs_div.sv
// Restoring divider: quotient of a by b, one bit per cycle.
module pfs_div (
  input  logic                     clk,
  input  logic                     rst,
  input  pfs_pkg::div_ctl_t        ctl,
  input  logic [pfs_pkg::VAL_W-1:0] a,
  input  logic [pfs_pkg::VAL_W-1:0] b,
  output pfs_pkg::div_sts_t        sts,
  output logic [pfs_pkg::VAL_W-1:0] quo
);
  import pfs_pkg::*;

  localparam int CW = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;

  assign trial = {rem, quo[VAL_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      sts.done <= 1'b0;
      cnt      <= '0;
    end else begin
      sts.done <= !ctl.start && busy && (cnt == CW'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(VAL_W);
        rem  <= '0;
        quo  <= a;
        dvs  <= b;
      end else if (busy) begin
        if (!diff[VAL_W]) begin
          rem <= diff[VAL_W-1:0];
          quo <= {quo[VAL_W-2:0], 1'b1};
        end else begin
          rem <= trial[VAL_W-1:0];
          quo <= {quo[VAL_W-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

// File: hdl/prime_factor_sieve_unit.sv
// Channel | Dir | Fields (low bit up)
// s_axis  | in  | tdata: operation[1:0], value[17:2], pad
// m_axis  | out | tdata: result_value, prime_count, status; tlast: last
// cfg     | in  | data: table_size[16:0]
// Build: clear each entry, then check each number in turn and mark the multiples of each prime.
// Factor: per factor, a table lookup, a pass through the bit-serial divider, then one output.
// Read: a lookup through the prime list read port. Output is registered.
// Synchronous reset; both memories are undefined until a build writes them.
// The block takes no item until its result transactions are all taken.
module prime_factor_sieve_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // operation[1:0], value[17:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value[15:0], prime_count[29:16], status[32:30]
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data        // table_size
);
  import pfs_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = $clog2(PRIME_SLOTS);
  localparam int IW = AW + 1;

  state_t state, state_next;

  logic [16:0]      table_size;
  logic             table_ready;
  logic [CNT_W-1:0] primes_found;
  logic [IW-1:0]    eff;
  logic [IW-1:0]    idx;       // sieve i / clear pointer
  logic [IW-1:0]    mul;       // multiple pointer
  logic [VAL_W-1:0] n;
  logic [4:0]       kcnt;
  logic [VAL_W-1:0] val;
  status_t          in_st;

  logic [VAL_W-1:0] o_val;
  status_t          o_st;
  logic             o_last;

  // table ram
  logic             t_we;
  logic [AW-1:0]    t_waddr, t_raddr;
  logic [VAL_W-1:0] t_wdata, t_rdata;
  logic             p_we;
  logic [PW-1:0]    p_waddr, p_raddr;
  logic [VAL_W-1:0] p_rdata;

  div_ctl_t         dctl;
  div_sts_t         dsts;
  logic [VAL_W-1:0] quo;

  always_comb begin
    if (table_size < 17'd2) eff = IW'(2);
    else if ({15'd0, table_size} > 32'(TABLE_ENTRIES)) eff = IW'(TABLE_ENTRIES);
    else eff = IW'(table_size);
  end

  pfs_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );
  pfs_ram #(.WIDTH(VAL_W), .DEPTH(PRIME_SLOTS)) u_plist (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(idx[VAL_W-1:0]),
    .raddr(p_raddr), .rdata(p_rdata)
  );
  pfs_div u_div (.clk, .rst, .ctl(dctl), .a(n), .b(t_rdata), .sts(dsts), .quo);

  assign s_axis_tready = (state == S_IDLE);
  // hold a register write while an item is offered
  assign cfg_ready     = (state == S_IDLE) && !s_axis_tvalid;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {7'd0, o_st, primes_found, o_val};
  assign m_axis_tlast  = o_last;

  // status of an offered item that ends in a single error transaction
  always_comb begin
    in_st = ST_OK;
    if (s_axis_tvalid) begin
      unique case (op_t'(s_axis_tdata[1:0]))
        OP_FACTOR: begin
          if (s_axis_tdata[17:2] < 16'd2) in_st = ST_BELOW_TWO;
          else if (IW'(s_axis_tdata[17:2]) >= eff) in_st = ST_OUTSIDE;
          else if (!table_ready) in_st = ST_NO_TABLE;
        end
        OP_READ: begin
          if (!table_ready) in_st = ST_NO_TABLE;
          else if (IW'(s_axis_tdata[17:2]) >= IW'(primes_found)) in_st = ST_PAST_END;
        end
        OP_BUILD: ;
        OP_NONE:  ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          unique case (op_t'(s_axis_tdata[1:0]))
            OP_BUILD:  state_next = S_B_CLR;
            OP_FACTOR: begin
              if (s_axis_tdata[17:2] < 16'd2 || IW'(s_axis_tdata[17:2]) >= eff
                  || !table_ready) state_next = S_OUT;
              else state_next = S_F_RD;
            end
            OP_READ:   state_next = (!table_ready || IW'(s_axis_tdata[17:2])
                                     >= IW'(primes_found)) ? S_OUT : S_R_RD;
            OP_NONE:   state_next = S_IDLE;
          endcase
        end
      end
      S_B_CLR:  if (idx == eff - IW'(1)) state_next = S_B_RD;
      S_B_RD:   state_next = (idx >= eff) ? S_OUT : S_B_CHK;
      S_B_CHK:  state_next = (t_rdata == '0) ? S_B_MARK : S_B_RD;
      S_B_MARK: if (mul >= eff) state_next = S_B_RD;
      S_F_RD:   state_next = S_F_WAIT;
      S_F_WAIT: state_next = (t_rdata < 16'd2) ? S_OUT : S_F_DIV;
      S_F_DIV:  if (dsts.done) state_next = S_OUT;
      S_R_RD:   state_next = S_R_WAIT;
      S_R_WAIT: state_next = S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          state_next = o_last ? S_IDLE : S_F_RD;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    t_we    = 1'b0;
    t_waddr = idx[AW-1:0];
    t_wdata = '0;
    t_raddr = idx[AW-1:0];
    p_we    = 1'b0;
    p_waddr = primes_found[PW-1:0];
    p_raddr = val[PW-1:0];
    dctl.start = 1'b0;
    unique case (state)
      S_B_CLR:  begin
        t_we    = 1'b1;
        t_wdata = (idx == IW'(1)) ? 16'd1 : 16'd0;
      end
      S_B_CHK:  begin
        if (t_rdata == '0) begin
          t_we    = 1'b1;
          t_wdata = idx[VAL_W-1:0];
          p_we    = (32'(primes_found) < PRIME_SLOTS);
        end
      end
      S_B_MARK: begin
        t_we    = (mul < eff);
        t_waddr = mul[AW-1:0];
        t_wdata = idx[VAL_W-1:0];
      end
      S_F_RD:   t_raddr = n[AW-1:0];
      S_F_WAIT: dctl.start = (t_rdata >= 16'd2);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      table_size   <= 17'd65536;
      table_ready  <= 1'b0;
      primes_found <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        table_size  <= cfg_data;
        table_ready <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          val    <= s_axis_tdata[17:2];
          n      <= s_axis_tdata[17:2];
          kcnt   <= '0;
          idx    <= '0;
          o_val  <= '0;
          o_last <= 1'b1;
          o_st   <= in_st;
          if (s_axis_tvalid && op_t'(s_axis_tdata[1:0]) == OP_BUILD) primes_found <= '0;
        end
        S_B_CLR: begin
          idx <= (idx == eff - IW'(1)) ? IW'(2) : idx + IW'(1);
        end
        S_B_RD: if (idx >= eff) table_ready <= 1'b1;
        S_B_CHK: begin
          if (t_rdata == '0) begin
            if (32'(primes_found) < PRIME_SLOTS) primes_found <= primes_found + CNT_W'(1);
            mul <= idx + idx;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_B_MARK: begin
          if (mul >= eff) idx <= idx + IW'(1);
          else mul <= mul + idx;
        end
        S_F_WAIT: begin
          if (t_rdata < 16'd2) begin
            // only possible on the first lookup
            o_st <= ST_NO_TABLE;
            o_val <= '0;
            o_last <= 1'b1;
          end else begin
            o_val <= t_rdata;
          end
        end
        S_F_DIV: begin
          if (dsts.done) begin
            n      <= quo;
            o_last <= (quo <= 16'd1) || (kcnt == 5'(MAX_OUT - 1));
            kcnt   <= kcnt + 5'd1;
          end
        end
        S_R_WAIT: o_val <= p_rdata;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && m_axis_tready) |=> s_axis_tready)
    else $error("no return to idle after last result");
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status_t'(m_axis_tdata[32:30]) != ST_OK) |-> m_axis_tlast)
    else $error("error result not marked last");
endmodule

// File: tb/sv/tb_prime_factor_sieve_unit.sv
module tb_prime_factor_sieve_unit;
  import pfs_pkg::*;

  localparam int TBL_N     = 65536;
  localparam int SLOT_N    = 8192;
  localparam int DRAIN_CYC = 60;

  typedef struct packed {
    logic [15:0] val;
    logic [13:0] cnt;
    status_t     st;
    logic        last;
  } sieve_res_t;

  typedef struct {
    op_t         op;
    logic [15:0] val;
    bit          typed;
    logic [15:0] exp_val;
    status_t     exp_st;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;

  // model copy of the block state
  int unsigned lpf_table[TBL_N];
  int unsigned prime_tab[SLOT_N];
  int unsigned n_primes;
  bit          sieve_ready;
  int unsigned size_reg;

  sieve_res_t  pending_res[$];
  int          n_errors;
  int          send_idle;
  int          recv_idle;

  prime_factor_sieve_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int unsigned eff_size();
    if (size_reg < 2) return 2;
    if (size_reg > TBL_N) return TBL_N;
    return size_reg;
  endfunction

  function automatic sieve_res_t mk_res(int unsigned v, status_t st, bit last);
    sieve_res_t r;
    r.val  = v[15:0];
    r.cnt  = n_primes[13:0];
    r.st   = st;
    r.last = last;
    return r;
  endfunction

  function automatic void run_sieve();
    int unsigned sz;
    sz = eff_size();
    foreach (lpf_table[i]) lpf_table[i] = 0;
    n_primes = 0;
    lpf_table[1] = 1;
    for (int unsigned i = 2; i < sz; i++) begin
      if (lpf_table[i] != 0) continue;
      lpf_table[i] = i;
      if (n_primes < SLOT_N) begin
        prime_tab[n_primes] = i;
        n_primes++;
      end
      for (int unsigned j = i + i; j < sz; j += i) lpf_table[j] = i;
    end
    sieve_ready = 1'b1;
  endfunction

  // work out the results of one accepted item, in emission order
  function automatic void predict_sieve_op(op_t op, int unsigned v, ref sieve_res_t res[$]);
    int unsigned n;
    int unsigned p;
    int          k;
    res.delete();
    case (op)
      OP_BUILD: begin
        run_sieve();
        res = {res, mk_res(0, ST_OK, 1'b1)};
      end
      OP_FACTOR: begin
        n = v;
        k = 0;
        if (n < 2) res = {res, mk_res(0, ST_BELOW_TWO, 1'b1)};
        else if (n >= eff_size()) res = {res, mk_res(0, ST_OUTSIDE, 1'b1)};
        else if (!sieve_ready) res = {res, mk_res(0, ST_NO_TABLE, 1'b1)};
        else begin
          while (n > 1 && k < MAX_OUT) begin
            p = lpf_table[n];
            if (p < 2) break;
            n = n / p;
            res = {res, mk_res(p, ST_OK, (n <= 1 || k == MAX_OUT - 1))};
            k++;
          end
          if (k == 0) res = {res, mk_res(0, ST_NO_TABLE, 1'b1)};
          else res[k-1].last = 1'b1;
        end
      end
      OP_READ: begin
        if (!sieve_ready) res = {res, mk_res(0, ST_NO_TABLE, 1'b1)};
        else if (v >= n_primes || v >= SLOT_N) res = {res, mk_res(0, ST_PAST_END, 1'b1)};
        else res = {res, mk_res(prime_tab[v], ST_OK, 1'b1)};
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(op_t op, logic [15:0] v, bit typed = 0,
                           logic [15:0] tv = 0, status_t tst = ST_OK);
    sieve_res_t res[$];
    while ($urandom_range(99) < send_idle) @(posedge clk);
    @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v, op};
    do @(posedge clk); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    predict_sieve_op(op, v, res);
    if (typed && res.size() == 1) begin
      res[0].val = tv;
      res[0].st  = tst;
    end
    foreach (res[i]) pending_res = {pending_res, res[i]};
  endtask

  task automatic wait_drained();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_size(logic [16:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg    = v;
    sieve_ready = 1'b0;
  endtask

  // mostly well-formed factor and read queries, some noise
  task automatic random_items(int cnt);
    int          pick;
    int unsigned sz;
    for (int i = 0; i < cnt; i++) begin
      pick = $urandom_range(99);
      sz   = eff_size();
      if (pick < 55 && sz > 2) send_item(OP_FACTOR, $urandom_range(sz - 1, 2));
      else if (pick < 80 && n_primes > 0) send_item(OP_READ, $urandom_range(n_primes - 1, 0));
      else if (pick < 86) send_item(OP_BUILD, $urandom_range(65535));
      else send_item(op_t'($urandom_range(3)), $urandom_range(65535));
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    sieve_res_t got;
    sieve_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[29:16], status_t'(m_axis_tdata[32:30]),
             m_axis_tlast};
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %h", $time, got);
        n_errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.val !== want.val)
          $display("%0t: result_value expected %0d actual %0d", $time, want.val, got.val);
        if (got.cnt !== want.cnt)
          $display("%0t: prime_count expected %0d actual %0d", $time, want.cnt, got.cnt);
        if (got.st !== want.st)
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
        if (got.last !== want.last)
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got !== want) n_errors++;
      end
    end
  end

  stim_row_t dir_rows[$];

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    n_errors      = 0;
    send_idle     = 13;
    recv_idle     = 46;
    n_primes      = 0;
    sieve_ready   = 1'b0;
    size_reg      = 65536;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // after reset: full size, no table
    dir_rows = '{
      '{OP_FACTOR, 16'd0,     1, 16'd0, ST_BELOW_TWO},
      '{OP_FACTOR, 16'd1,     1, 16'd0, ST_BELOW_TWO},
      '{OP_FACTOR, 16'd65535, 1, 16'd0, ST_NO_TABLE},
      '{OP_READ,   16'd0,     1, 16'd0, ST_NO_TABLE},
      '{OP_NONE,   16'd65535, 0, 16'd0, ST_OK},
      '{OP_READ,   16'd65535, 1, 16'd0, ST_NO_TABLE}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                dir_rows[i].exp_val, dir_rows[i].exp_st);

    write_size(17'd5);
    dir_rows = '{
      '{OP_BUILD,  16'd0,     1, 16'd0, ST_OK},
      '{OP_FACTOR, 16'd4,     0, 16'd0, ST_OK},
      '{OP_FACTOR, 16'd5,     1, 16'd0, ST_OUTSIDE},
      '{OP_READ,   16'd1,     1, 16'd3, ST_OK},
      '{OP_READ,   16'd2,     1, 16'd0, ST_PAST_END},
      '{OP_FACTOR, 16'd65535, 1, 16'd0, ST_OUTSIDE}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                dir_rows[i].exp_val, dir_rows[i].exp_st);

    // zero acts as the smallest size: no primes at all
    write_size(17'd0);
    send_item(OP_BUILD, 16'hFFFF, 1, 16'd0, ST_OK);
    send_item(OP_FACTOR, 16'd2, 1, 16'd0, ST_OUTSIDE);
    send_item(OP_READ, 16'd0, 1, 16'd0, ST_PAST_END);

    write_size(17'd65536);
    write_size(17'h1FFFF);
    send_item(OP_FACTOR, 16'd3, 1, 16'd0, ST_NO_TABLE);
    send_item(OP_BUILD, 16'd0, 1, 16'd0, ST_OK);
    send_item(OP_FACTOR, 16'd65535);
    send_item(OP_FACTOR, 16'd65534);
    send_item(OP_FACTOR, 16'd32768);
    send_item(OP_FACTOR, 16'd65521);
    send_item(OP_READ, 16'd6541, 1, 16'd65521, ST_OK);
    send_item(OP_READ, 16'd6542, 1, 16'd0, ST_PAST_END);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 13 : (mode == 1) ? 46 : 0;
      recv_idle = (mode == 0) ? 46 : (mode == 1) ? 13 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        if (mode == 1 && ph == 2) write_size(17'd4096);
        else write_size($urandom_range(600, 2));
        send_item(OP_BUILD, $urandom_range(65535));
        random_items(13);
        // hold off until the block has flushed every result
        wait_drained();
        random_items(13);
      end
    end

    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
